### rtl/fmcb_pkg.sv
// ----------------------------------------------------------------------------
// fmcb_pkg
// Shared types and constants of the FM-index checkpoint builder: beat
// structures, record types, register indexes and parameter defaults.
// ----------------------------------------------------------------------------
package fmcb_pkg;

  localparam int MAX_SYMBOLS_DEF = 27;
  localparam int COUNT_BITS_DEF  = 32;

  localparam logic [10:0] GAP_MAX = 11'd1024;

  localparam logic [1:0] REC_CHECKPOINT = 2'd0;
  localparam logic [1:0] REC_CUMULATIVE = 2'd1;
  localparam logic [1:0] REC_ERROR      = 2'd2;

  localparam logic REG_ALPHA_SIZE     = 1'b0;
  localparam logic REG_CHECKPOINT_GAP = 1'b1;

  typedef struct packed {
    logic [4:0] symbol;
    logic       final_req;
  } sym_beat_t;

  typedef struct packed {
    logic [1:0]  record_type;
    logic [31:0] checkpoint_index;
    logic [4:0]  symbol_code;
    logic [31:0] count;
    logic        run_end;
  } rec_beat_t;

endpackage

### rtl/fmcb_count_store.sv
// ----------------------------------------------------------------------------
// fmcb_count_store
// Per-symbol occurrence counts in a synchronous memory with a registered read.
// Valid bits per entry make a cleared entry read as zero.
// ----------------------------------------------------------------------------
module fmcb_count_store #(
  parameter int MAX_SYMBOLS = fmcb_pkg::MAX_SYMBOLS_DEF,
  parameter int COUNT_BITS  = fmcb_pkg::COUNT_BITS_DEF,
  localparam int ADDR_W     = $clog2(MAX_SYMBOLS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  logic [ADDR_W-1:0]     rd_addr,
  output logic [COUNT_BITS-1:0] rd_data,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  logic [COUNT_BITS-1:0] wr_data
);

  logic [COUNT_BITS-1:0] mem [MAX_SYMBOLS];
  logic [MAX_SYMBOLS-1:0] vld;
  logic [COUNT_BITS-1:0] q;
  logic                  q_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      vld   <= '0;
      q_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      q_vld <= vld[rd_addr];
    end
  end

  assign rd_data = q_vld ? q : '0;

endmodule

### rtl/fm_index_checkpoint_builder.sv
// Flow: a symbol that yields no record passes through the count update state
// back to idle; an invalid symbol gives its error record from the error state.
// Each checkpoint or cumulative record takes a count memory read, then the
// output register; a checkpoint burst holds alpha_size+1 records and a final
// burst one more, and any output stall holds them. A new symbol beat is taken
// only once the last is through. Reset is synchronous and clears all counts.
// ----------------------------------------------------------------------------
// fm_index_checkpoint_builder
// Counts symbols of a transformed string and emits sampled occurrence count
// checkpoints, error records and the cumulative symbol starts at string end.
// ----------------------------------------------------------------------------
module fm_index_checkpoint_builder #(
  parameter int MAX_SYMBOLS = fmcb_pkg::MAX_SYMBOLS_DEF,
  parameter int COUNT_BITS  = fmcb_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sym_valid,
  output logic                sym_ready,
  input  fmcb_pkg::sym_beat_t sym_data,
  output logic                rec_valid,
  input  logic                rec_ready,
  output fmcb_pkg::rec_beat_t rec_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [10:0]         cfg_data
);

  localparam int ADDR_W = $clog2(MAX_SYMBOLS);
  localparam logic [4:0] ALPHA_MAX = 5'(MAX_SYMBOLS - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INC  = 3'd1;
  localparam logic [2:0] ST_ERR  = 3'd2;
  localparam logic [2:0] ST_CUM0 = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  function automatic logic [31:0] to32(input logic [COUNT_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                    input logic [COUNT_BITS-1:0] b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
  endfunction

  logic [4:0]  alpha_size;
  logic [10:0] checkpoint_gap;

  logic [2:0]  state, state_next;
  logic [4:0]  sym;
  logic        fin;
  logic [4:0]  alpha_c;
  logic [10:0] gap_c;
  logic [9:0]  gap_phase;
  logic [31:0] ckpt_num;
  logic [ADDR_W-1:0]     k;
  logic                  cum;
  logic [COUNT_BITS-1:0] acc;

  logic                  accept;
  logic                  slot_free;
  logic                  load;
  fmcb_pkg::rec_beat_t   rec_next;
  logic [ADDR_W-1:0]     rd_addr;
  logic [COUNT_BITS-1:0] rd_data;
  logic                  wr_en;
  logic                  clear;
  logic [10:0]           phase_inc;
  logic                  last_k;
  logic [COUNT_BITS-1:0] sum;
  logic [4:0]            alpha_in;
  logic [10:0]           gap_in;

  assign sym_ready = (state == ST_IDLE);
  assign accept    = sym_valid && sym_ready;
  assign slot_free = !rec_valid || rec_ready;
  assign phase_inc = 11'(gap_phase) + 11'd1;
  assign last_k    = (5'(k) == alpha_c);
  assign sum       = sat_add(acc, rd_data);

  always_comb begin
    if (alpha_size == 5'd0) begin
      alpha_in = 5'd1;
    end else if (alpha_size > ALPHA_MAX) begin
      alpha_in = ALPHA_MAX;
    end else begin
      alpha_in = alpha_size;
    end
    if (checkpoint_gap == 11'd0) begin
      gap_in = 11'd1;
    end else if (checkpoint_gap > fmcb_pkg::GAP_MAX) begin
      gap_in = fmcb_pkg::GAP_MAX;
    end else begin
      gap_in = checkpoint_gap;
    end
  end

  assign rd_addr = (state == ST_IDLE) ? ADDR_W'(sym_data.symbol) : k;
  assign wr_en   = (state == ST_INC);
  assign clear   = (state == ST_EMIT) && slot_free && cum && last_k;

  fmcb_count_store #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .clear   (clear),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (ADDR_W'(sym)),
    .wr_data ((&rd_data) ? rd_data : rd_data + 1'b1)
  );

  always_comb begin
    state_next = state;
    load       = 1'b0;
    rec_next   = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (sym_data.symbol > alpha_in) ? ST_ERR : ST_INC;
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          load                 = 1'b1;
          rec_next.record_type = fmcb_pkg::REC_ERROR;
          rec_next.symbol_code = sym;
          rec_next.run_end     = !fin;
          state_next           = fin ? ST_CUM0 : ST_IDLE;
        end
      end
      ST_INC: begin
        if (phase_inc >= gap_c) begin
          state_next = ST_RD;
        end else if (fin) begin
          state_next = ST_CUM0;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_CUM0: begin
        if (slot_free) begin
          load                 = 1'b1;
          rec_next.record_type = fmcb_pkg::REC_CUMULATIVE;
          state_next           = ST_RD;
        end
      end
      ST_RD: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          load = 1'b1;
          if (cum) begin
            rec_next.record_type = fmcb_pkg::REC_CUMULATIVE;
            rec_next.symbol_code = 5'(k) + 5'd1;
            rec_next.count       = to32(sum);
            rec_next.run_end     = last_k;
            state_next           = last_k ? ST_IDLE : ST_RD;
          end else begin
            rec_next.record_type      = fmcb_pkg::REC_CHECKPOINT;
            rec_next.checkpoint_index = ckpt_num;
            rec_next.symbol_code      = 5'(k);
            rec_next.count            = to32(rd_data);
            rec_next.run_end          = last_k && !fin;
            if (last_k) begin
              state_next = fin ? ST_CUM0 : ST_IDLE;
            end else begin
              state_next = ST_RD;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_size     <= 5'd4;
      checkpoint_gap <= 11'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        fmcb_pkg::REG_ALPHA_SIZE:     alpha_size     <= cfg_data[4:0];
        fmcb_pkg::REG_CHECKPOINT_GAP: checkpoint_gap <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rec_valid <= 1'b0;
      gap_phase <= '0;
      ckpt_num  <= 32'd1;
    end else begin
      state <= state_next;
      if (load) begin
        rec_valid <= 1'b1;
      end else if (rec_ready) begin
        rec_valid <= 1'b0;
      end
      if (state == ST_INC) begin
        gap_phase <= (phase_inc >= gap_c) ? 10'd0 : phase_inc[9:0];
      end
      if (state == ST_EMIT && slot_free && last_k) begin
        if (cum) begin
          gap_phase <= '0;
          ckpt_num  <= 32'd1;
        end else if (ckpt_num != '1) begin
          ckpt_num <= ckpt_num + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec_data <= rec_next;
    end
    if (accept) begin
      sym     <= sym_data.symbol;
      fin     <= sym_data.final_req;
      alpha_c <= alpha_in;
      gap_c   <= gap_in;
    end
    case (state)
      ST_INC: begin
        k   <= '0;
        cum <= 1'b0;
      end
      ST_CUM0: begin
        k   <= '0;
        cum <= 1'b1;
        acc <= '0;
      end
      ST_EMIT: begin
        if (slot_free) begin
          acc <= sum;
          if (!last_k) begin
            k <= k + 1'b1;
          end else begin
            k <= '0;
          end
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_one_beat_per_item: assert property (@(posedge clk) disable iff (rst)
    (sym_valid && sym_ready) |=> !sym_ready)
    else $error("a second symbol beat was taken while one was in progress");

  a_ckpt_nonzero: assert property (@(posedge clk) disable iff (rst)
    ckpt_num != 32'd0)
    else $error("checkpoint number reached zero");

  a_inc_follows_accept: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INC) |-> ($past(state) == ST_IDLE))
    else $error("count update without a preceding symbol beat");
`endif

endmodule
